[hdl/gyro_serial_frame_parser_assert.svh]
// Assertion macros for the gyro frame parser RTL.
`ifndef GYRO_SERIAL_FRAME_PARSER_ASSERT_SVH
`define GYRO_SERIAL_FRAME_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define GSFP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gsfp: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define GSFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gsfp: next-cycle check failed");

`endif

[hdl/gsfp_pkg.sv]
// Types and constants of the gyro serial frame parser.
package gsfp_pkg;

   localparam int unsigned RX_W        = 8;
   localparam int unsigned GROUP_W     = 7;
   localparam int unsigned VALUE_W     = 32;
   localparam int unsigned COUNT_W     = 3;
   localparam int unsigned STORE_DEPTH = 5;
   localparam int unsigned TEMP_SHIFT  = 4;   // divide by 16
   localparam int unsigned TEMP_RAW_W  = 2 * GROUP_W;
   localparam int unsigned TEMP_VAL_W  = TEMP_RAW_W - TEMP_SHIFT;
   localparam int unsigned TOP_BITS    = VALUE_W - 4 * GROUP_W;  // bits kept of the fifth group

   localparam logic [RX_W-1:0]    SYNC_BYTE  = 8'h80;
   localparam logic [COUNT_W-1:0] RATE_BYTES = 3'd5;
   localparam logic [COUNT_W-1:0] TEMP_BYTES = 3'd2;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_RATE = 2'd1,
      PH_TEMP = 2'd2
   } phase_type;

   typedef enum logic {
      KIND_RATE = 1'b0,
      KIND_TEMP = 1'b1
   } kind_type;

   typedef struct packed {
      logic               valid;
      kind_type           kind;
      logic [VALUE_W-1:0] value;
   } result_type;

endpackage

[hdl/gsfp_frame_fsm.sv]
// Frame state machine: sync hunt, payload capture, check and word assembly.
module gsfp_frame_fsm (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic [gsfp_pkg::RX_W-1:0] rx_byte,
   output gsfp_pkg::result_type      result
);

   gsfp_pkg::phase_type               phase_ff, phase_in;
   logic [gsfp_pkg::COUNT_W-1:0]      count_ff, count_in;
   logic [gsfp_pkg::GROUP_W-1:0]      store_ff [gsfp_pkg::STORE_DEPTH];
   logic                              store_we;
   logic                              high_bit;
   logic                              rate_ok, temp_ok;
   logic [gsfp_pkg::TEMP_RAW_W-1:0]   temp_raw;

   assign high_bit = rx_byte[gsfp_pkg::RX_W-1];
   assign rate_ok  = (store_ff[0] ^ store_ff[1] ^ store_ff[2] ^ store_ff[3] ^ store_ff[4])
                     == rx_byte[gsfp_pkg::GROUP_W-1:0];
   assign temp_ok  = (store_ff[0] ^ store_ff[1]) == rx_byte[gsfp_pkg::GROUP_W-1:0];
   assign temp_raw = {store_ff[1], store_ff[0]};

   // next state
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      unique case (phase_ff)
         gsfp_pkg::PH_IDLE: begin
            if (rx_byte == gsfp_pkg::SYNC_BYTE) begin
               phase_in = gsfp_pkg::PH_RATE;
               count_in = '0;
            end
         end
         gsfp_pkg::PH_RATE: begin
            if (high_bit) begin
               phase_in = gsfp_pkg::PH_IDLE;
            end else if (count_ff < gsfp_pkg::RATE_BYTES) begin
               count_in = count_ff + 1'b1;
            end else if (rate_ok) begin
               phase_in = gsfp_pkg::PH_TEMP;
               count_in = '0;
            end else begin
               phase_in = gsfp_pkg::PH_IDLE;
            end
         end
         gsfp_pkg::PH_TEMP: begin
            if (high_bit) begin
               phase_in = gsfp_pkg::PH_IDLE;
            end else if (count_ff < gsfp_pkg::TEMP_BYTES) begin
               count_in = count_ff + 1'b1;
            end else begin
               phase_in = gsfp_pkg::PH_IDLE;
               if (temp_ok) begin
                  count_in = '0;
               end
            end
         end
         default: begin
            phase_in = gsfp_pkg::PH_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      store_we     = 1'b0;
      result.valid = 1'b0;
      result.kind  = gsfp_pkg::KIND_RATE;
      result.value = {store_ff[4][gsfp_pkg::TOP_BITS-1:0], store_ff[3], store_ff[2],
                      store_ff[1], store_ff[0]};
      unique case (phase_ff)
         gsfp_pkg::PH_RATE: begin
            store_we     = !high_bit && (count_ff < gsfp_pkg::RATE_BYTES);
            result.valid = !high_bit && (count_ff >= gsfp_pkg::RATE_BYTES) && rate_ok;
         end
         gsfp_pkg::PH_TEMP: begin
            store_we     = !high_bit && (count_ff < gsfp_pkg::TEMP_BYTES);
            result.valid = !high_bit && (count_ff >= gsfp_pkg::TEMP_BYTES) && temp_ok;
            result.kind  = gsfp_pkg::KIND_TEMP;
            result.value = {{(gsfp_pkg::VALUE_W - gsfp_pkg::TEMP_VAL_W){1'b0}},
                            temp_raw[gsfp_pkg::TEMP_RAW_W-1:gsfp_pkg::TEMP_SHIFT]};
         end
         default: begin
            store_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= gsfp_pkg::PH_IDLE;
         count_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   // capture payload groups; entries are always rewritten before a check reads them
   always_ff @(posedge clock) begin
      if (step && store_we) begin
         store_ff[count_ff] <= rx_byte[gsfp_pkg::GROUP_W-1:0];
      end
   end

endmodule

[hdl/gyro_serial_frame_parser.sv]
// Top level of the gyro serial frame parser: input register, frame FSM, result register.
`include "gyro_serial_frame_parser_assert.svh"

// Parses the byte stream of a gyro sensor link, one received byte per transfer on the
// req_ channel. While idle the parser hunts for the sync byte 0x80; a rate frame follows
// as five 7-bit payload bytes and an XOR check byte, then a temperature frame as two
// 7-bit bytes and their XOR check. A passed rate frame gives a result with tuser = 0 and
// tdata = the 32-bit signed rate word (7-bit groups, least significant first, bits above
// 31 dropped). A passed temperature frame gives tuser = 1 and tdata = the 14-bit
// temperature divided by 16 (0..1023). Any byte with bit 7 set inside a frame, or a
// failed check, drops back to sync hunt without a result, and that byte is never taken
// as a new sync. Throughput is one byte per clock while rsp_tready stays high. A byte is
// registered on entry in the input register; its frame-state update and result assembly
// pass combinationally through the FSM into the result register, which drives
// rsp_tvalid. A result waiting in the result register holds the byte in the input
// register, whether or not that byte would give a result, so req_tready drops as soon
// as a result stalls with a byte held and stays low until the result transfers. No CSRs.
module gyro_serial_frame_parser (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [gsfp_pkg::RX_W-1:0]    req_tdata,   // [7:0] rx_byte
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [gsfp_pkg::VALUE_W-1:0] rsp_tdata,   // [31:0] frame_value (signed)
   output logic                         rsp_tuser    // [0] frame_kind
);

   // input register
   logic                          s1_valid_ff, s1_valid_in;
   logic [gsfp_pkg::RX_W-1:0]     s1_byte_ff;
   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   gsfp_pkg::kind_type            rsp_kind_ff;
   logic [gsfp_pkg::VALUE_W-1:0]  rsp_value_ff;

   logic                          req_xfer;
   logic                          advance;
   gsfp_pkg::result_type          result;
   logic                          byte_held;
   logic                          temp_in_range;

   // advance the held byte through the FSM when the result register is free or draining
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;

   gsfp_frame_fsm u_fsm (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (s1_byte_ff),
      .result  (result)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = result.valid;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers: byte on transfer, result on FSM result; hold otherwise
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_byte_ff <= req_tdata;
      end
      if (advance && result.valid) begin
         rsp_kind_ff  <= result.kind;
         rsp_value_ff <= result.value;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_kind_ff;

   assign byte_held     = s1_valid_ff && !advance;
   assign temp_in_range = (rsp_kind_ff != gsfp_pkg::KIND_TEMP) ||
                          (rsp_value_ff[gsfp_pkg::VALUE_W-1:gsfp_pkg::TEMP_VAL_W] == '0);

   // a temperature result never exceeds the 10-bit range
   `GSFP_ASSERT_IMPL(a_temp_range, clock, reset, rsp_valid_ff, temp_in_range)
   // a byte that cannot advance stays in the input register unchanged
   `GSFP_ASSERT_NEXT(a_hold_byte, clock, reset, byte_held, s1_valid_ff && $stable(s1_byte_ff))
   // every result the FSM produces lands in the result register
   `GSFP_ASSERT_NEXT(a_result_load, clock, reset, advance && result.valid, rsp_valid_ff)

endmodule

[tb/sv/gsfp_frame_checker.sv]
// Frame checker for the gyro serial frame parser: predicts results from accepted bytes.
`timescale 1ns / 100ps

module gsfp_frame_checker
   import gsfp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tready,
   input  logic [RX_W-1:0]    req_tdata,
   input  logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  logic [VALUE_W-1:0] rsp_tdata,
   input  logic               rsp_tuser,
   output int unsigned        mismatch_count,
   output int unsigned        frames_waiting
);

   typedef struct {
      kind_type           kind;
      logic [VALUE_W-1:0] value;
   } frame_t;

   frame_t             expected_frames[$];
   phase_type          parse_phase;
   logic [COUNT_W-1:0] group_count;
   logic [GROUP_W-1:0] groups [STORE_DEPTH];
   int unsigned        rsp_index;

   task automatic report_mismatch(input string what);
      $display("[%0t] result %0d: %s", $time, rsp_index, what);
      mismatch_count++;
   endtask

   task automatic drop_to_idle();
      parse_phase = PH_IDLE;
      foreach (groups[i]) groups[i] = '0;
   endtask

   // Advance the parser state by one received byte; queue a frame when a check passes.
   task automatic parse_rx_byte(input logic [RX_W-1:0] rx);
      logic [GROUP_W-1:0]    check;
      logic [TEMP_RAW_W-1:0] raw_temp;
      frame_t                frame;
      case (parse_phase)
         PH_IDLE: begin
            if (rx == SYNC_BYTE) begin
               parse_phase = PH_RATE;
               group_count = '0;
            end
         end
         PH_RATE: begin
            if (rx[RX_W-1]) begin
               drop_to_idle();
            end else if (group_count < RATE_BYTES) begin
               groups[group_count] = rx[GROUP_W-1:0];
               group_count++;
            end else begin
               check = groups[0] ^ groups[1] ^ groups[2] ^ groups[3] ^ groups[4];
               if (check != rx[GROUP_W-1:0]) begin
                  drop_to_idle();
               end else begin
                  frame.kind  = KIND_RATE;
                  frame.value = {groups[4][TOP_BITS-1:0], groups[3], groups[2],
                                 groups[1], groups[0]};
                  expected_frames.push_back(frame);
                  group_count = '0;
                  parse_phase = PH_TEMP;
                  foreach (groups[i]) groups[i] = '0;
               end
            end
         end
         PH_TEMP: begin
            if (rx[RX_W-1]) begin
               drop_to_idle();
            end else if (group_count < TEMP_BYTES) begin
               groups[group_count] = rx[GROUP_W-1:0];
               group_count++;
            end else begin
               check = groups[0] ^ groups[1];
               if (check != rx[GROUP_W-1:0]) begin
                  drop_to_idle();
               end else begin
                  // store stays as it is after a good temperature frame
                  raw_temp    = {groups[1], groups[0]};
                  frame.kind  = KIND_TEMP;
                  frame.value = {{(VALUE_W-TEMP_VAL_W){1'b0}},
                                 raw_temp[TEMP_RAW_W-1:TEMP_SHIFT]};
                  expected_frames.push_back(frame);
                  group_count = '0;
                  parse_phase = PH_IDLE;
               end
            end
         end
         default: drop_to_idle();
      endcase
   endtask

   task automatic compare_result();
      frame_t want;
      if (expected_frames.size() == 0) begin
         report_mismatch($sformatf("unexpected result, kind %0d value %h",
                                   rsp_tuser, rsp_tdata));
      end else begin
         want = expected_frames.pop_front();
         if (rsp_tuser !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", rsp_tuser, want.kind));
         if (rsp_tdata !== want.value)
            report_mismatch($sformatf("value %h, expected %h", rsp_tdata, want.value));
      end
      rsp_index++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_frames.delete();
         parse_phase    = PH_IDLE;
         group_count    = '0;
         foreach (groups[i]) groups[i] = '0;
         mismatch_count = 0;
         rsp_index      = 0;
      end else begin
         if (req_tvalid && req_tready)
            parse_rx_byte(req_tdata);
         if (rsp_tvalid && rsp_tready)
            compare_result();
      end
      frames_waiting = expected_frames.size();
   end

endmodule

[tb/sv/tb_top.sv]
// Top of the gyro serial frame parser testbench: clock, reset, byte stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
   import gsfp_pkg::*;

   localparam int unsigned RESET_CYCLES = 12;
   localparam int unsigned STREAM_BYTES = 1450;   // frame bytes to offer before stopping
   localparam int unsigned PRESSURE_AT  = 300;    // receiver cycle at which the long hold starts
   localparam int unsigned PRESSURE_LEN = 400;
   localparam int unsigned DRAIN_CYCLES = 100;
   localparam int unsigned CYCLE_LIMIT  = 500000;

   // Opening bytes, in order:
   //  - a non-sync byte while hunting, which must be ignored
   //  - a frame with every payload bit set: rate word all ones (top bits of the fifth
   //    group dropped), temperature at its maximum
   //  - a sync byte inside a rate frame: abort, and do not restart on it
   //  - an all-zero rate frame, then a temperature frame with a bad check
   localparam logic [RX_W-1:0] OPENING [25] = '{
      8'hFF,
      SYNC_BYTE, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h00,
      SYNC_BYTE, 8'h01, SYNC_BYTE, 8'h00,
      SYNC_BYTE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01
   };

   logic               clock = 1'b0;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   logic [RX_W-1:0]    req_tdata;      // [7:0] rx_byte
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [VALUE_W-1:0] rsp_tdata;      // [31:0] frame_value (signed)
   logic               rsp_tuser;      // [0] frame_kind

   int unsigned        mismatch_count;
   int unsigned        frames_waiting;
   int unsigned        cycle_count = 0;
   int unsigned        stream_bytes = 0;
   bit                 steady_send = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   gyro_serial_frame_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   gsfp_frame_checker frame_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .frames_waiting (frames_waiting)
   );

   // Idle length for either side: mostly none or short, now and then long.
   // A steady stretch never idles.
   function automatic int unsigned pick_gap(input bit steady);
      int unsigned roll;
      if (steady)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Payload group: bias toward the extremes now and then.
   function automatic logic [GROUP_W-1:0] pick_group();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll == 0)
         return '0;
      if (roll == 1)
         return '1;
      return GROUP_W'($urandom_range(0, 127));
   endfunction

   // Offer one byte and hold it until the transfer happens. Enter and leave at a
   // falling edge; drop tvalid only across a real gap so it never toggles in one step.
   task automatic send_byte(input logic [RX_W-1:0] rx);
      int unsigned gap;
      gap = pick_gap(steady_send);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rx;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // Build a full rate + temperature frame with random content, then maybe spoil it:
   // a bad rate check, a bad temperature check, a high-bit byte inside the frame, or
   // a cut-off frame whose remainder is never sent.
   task automatic send_random_frame();
      logic [RX_W-1:0]    frame_bytes [10];
      logic [GROUP_W-1:0] rate_check;
      logic [GROUP_W-1:0] temp_check;
      int unsigned        flaw;
      int unsigned        cut;
      frame_bytes[0] = SYNC_BYTE;
      rate_check     = '0;
      for (int i = 1; i <= 5; i++) begin
         frame_bytes[i] = {1'b0, pick_group()};
         rate_check     = rate_check ^ frame_bytes[i][GROUP_W-1:0];
      end
      frame_bytes[6] = {1'b0, rate_check};
      frame_bytes[7] = {1'b0, pick_group()};
      frame_bytes[8] = {1'b0, pick_group()};
      temp_check     = frame_bytes[7][GROUP_W-1:0] ^ frame_bytes[8][GROUP_W-1:0];
      frame_bytes[9] = {1'b0, temp_check};
      cut  = 10;
      flaw = $urandom_range(0, 99);
      if (flaw < 8)
         frame_bytes[6] = frame_bytes[6] ^ RX_W'($urandom_range(1, 127));
      else if (flaw < 14)
         frame_bytes[9] = frame_bytes[9] ^ RX_W'($urandom_range(1, 127));
      else if (flaw < 22)
         frame_bytes[$urandom_range(1, 9)] = RX_W'($urandom_range(128, 255));
      else if (flaw < 27)
         cut = $urandom_range(2, 9);
      for (int i = 0; i < cut; i++)
         send_byte(frame_bytes[i]);
      stream_bytes += cut;
   endtask

   // Run limit: end with a failure if the run hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Receiver: random stalls, steady stretches, and one long hold that lets the block
   // fill up and push back on its input while the sender keeps offering bytes.
   initial begin
      int unsigned hold_left;
      int unsigned since_reset;
      bit          steady_recv;
      rsp_tready  = 1'b0;
      hold_left   = 0;
      since_reset = 0;
      steady_recv = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         since_reset++;
         if ($urandom_range(0, 31) == 0)
            steady_recv = !steady_recv;
         if (since_reset == PRESSURE_AT)
            hold_left = PRESSURE_LEN;
         else if (hold_left == 0)
            hold_left = pick_gap(steady_recv);
         rsp_tready <= (hold_left == 0);
         if (hold_left != 0)
            hold_left--;
         @(negedge clock);
      end
   end

   // Sender: reset, opening bytes, then random frames mixed with line noise.
   initial begin
      int unsigned mix;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (OPENING[i])
         send_byte(OPENING[i]);
      stream_bytes = $size(OPENING);

      while (stream_bytes < STREAM_BYTES) begin
         if ($urandom_range(0, 15) == 0)
            steady_send = !steady_send;
         mix = $urandom_range(0, 99);
         // noise bytes are mostly ignored by the hunt, so leave them out of the count
         if (mix < 10)
            repeat ($urandom_range(1, 3)) send_byte(RX_W'($urandom_range(0, 255)));
         else
            send_random_frame();
      end
      req_tvalid <= 1'b0;

      // drain: wait out every expected frame, then watch a while for strays
      while (frames_waiting != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
